/* rtl/ffsa_pkg.sv */
// ----------------------------------------------------------------------------
// ffsa_pkg: shared definitions of the first fit segment allocator
// Operation codes, default sizes and the control group that drives the
// row of segment cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

  // default table depth and offset width
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_OFFSET_BITS  = 20;

  // width of the pool size register
  localparam int CFG_W = 21;

  // request operation codes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // control group broadcast to every cell
  typedef struct packed {
    logic ins;         // open a slot at idx and load the new segment
    logic rem;         // close the slot at idx
    logic scan_start;  // place the scan token on the first cell
  } ffsa_ctl_t;

endpackage

`default_nettype wire

/* rtl/first_fit_segment_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_segment_allocator: first fit bookkeeping for a memory pool
// Keeps an offset-ordered table of segments in a row of cells and serves
// allocate, free, resize and clear requests with first fit placement.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall; one result per request leaves on
//   out_valid/out_stall. pool_size is written through cfg_write/cfg_data;
//   the user must do so only while the block is idle, the block itself
//   does not enforce it. A transaction is taken when valid is high and
//   stall is low.
//   One request is worked on at a time. A scan token walks the cell row one
//   segment per cycle. An allocate walks the gaps, a free walks the table
//   for its segment and a resize may walk both; the result enters the
//   output register as the block returns to idle, where the next request
//   can be taken. Insert and remove shift every cell of the row together.
//   A stalled result holds in the output register and the block waits with
//   its next result until the register is free.
//   Reset empties the table and clears the pool size; table entries hold no
//   reset value and are never read beyond the segment count.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS,
  parameter int OFFSET_BITS  = ffsa_pkg::DEF_OFFSET_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [ffsa_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  operation,
  input  wire logic                        has_block,
  input  wire logic [OFFSET_BITS-1:0]      block_offset,
  input  wire logic [OFFSET_BITS:0]        size,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             has_result,
  output logic [OFFSET_BITS-1:0]           result_offset,
  output logic                             moved,
  output logic [OFFSET_BITS:0]             copy_length
);

  localparam int OB = OFFSET_BITS;
  localparam int SW = OB + 1;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int UW = (SW > ffsa_pkg::CFG_W) ? SW : ffsa_pkg::CFG_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_SEGMENTS);

  // controller states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_ACHK  = 3'd3;
  localparam logic [2:0] S_ASCAN = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [ffsa_pkg::CFG_W-1:0] pool_size;
  logic [2:0]                 state, state_next;
  logic [CW-1:0]              count, count_next;
  logic [IW-1:0]              k, k_next;
  logic [1:0]                 op;
  logic                       hb;
  logic [OB-1:0]              off;
  logic [SW-1:0]              req_size;
  logic                       rz, rz_next;
  logic [OB-1:0]              os, os_next;
  logic [SW-1:0]              oe, oe_next;
  logic [IW-1:0]              ridx, ridx_next;
  logic                       res_ok, res_ok_next;
  logic [OB-1:0]              res_off, res_off_next;
  logic                       res_moved, res_moved_next;
  logic [SW-1:0]              res_copy, res_copy_next;

  ffsa_pkg::ffsa_ctl_t        ctl;
  logic [IW-1:0]              c_idx;
  logic [OB-1:0]              c_new_start;
  logic [SW-1:0]              c_new_end;

  logic [OB-1:0]              c_start [MAX_SEGMENTS];
  logic [SW-1:0]              c_end   [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0]    c_tok, c_match, c_fit;

  logic [UW-1:0]              pool_x, lim_x;
  logic [SW-1:0]              pool_u;
  logic [OB-1:0]              sel_start;
  logic [SW-1:0]              sel_end;
  logic                       any_match, any_fit, last_k;
  logic [SW-1:0]              old_len;
  logic                       resp_go;

  // pool size register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= '0;
    end else if (cfg_write) begin
      pool_size <= cfg_data;
    end
  end

  // usable pool is capped at the offset range
  assign pool_x = UW'(pool_size);
  assign lim_x  = UW'(1) << OB;
  assign pool_u = SW'((pool_x > lim_x) ? lim_x : pool_x);

  // row of segment cells
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    logic [OB-1:0] l_start, r_start, n_start;
    logic [SW-1:0] l_end, r_end;
    logic          t_prev;
    if (i == 0) begin : g_first
      assign l_start = '0;
      assign l_end   = '0;
      assign t_prev  = 1'b0;
    end else begin : g_mid
      assign l_start = c_start[i-1];
      assign l_end   = c_end[i-1];
      assign t_prev  = c_tok[i-1];
    end
    if (i == MAX_SEGMENTS - 1) begin : g_last
      assign r_start = c_start[i];
      assign r_end   = c_end[i];
      assign n_start = c_start[i];
    end else begin : g_inner
      assign r_start = c_start[i+1];
      assign r_end   = c_end[i+1];
      assign n_start = c_start[i+1];
    end
    ffsa_cell #(
      .POS        (i),
      .OFFSET_BITS(OFFSET_BITS),
      .MAXS       (MAX_SEGMENTS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .idx        (c_idx),
      .new_start  (c_new_start),
      .new_end    (c_new_end),
      .left_start (l_start),
      .left_end   (l_end),
      .right_start(r_start),
      .right_end  (r_end),
      .next_start (n_start),
      .tok_prev   (t_prev),
      .count      (count),
      .pool       (pool_u),
      .size       (req_size),
      .off        (off),
      .seg_start  (c_start[i]),
      .seg_end    (c_end[i]),
      .tok        (c_tok[i]),
      .match      (c_match[i]),
      .fit        (c_fit[i])
    );
  end

  // pick the values of the cell that holds the token
  always_comb begin
    sel_start = '0;
    sel_end   = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      sel_start = sel_start | (c_start[i] & {OB{c_tok[i]}});
      sel_end   = sel_end   | (c_end[i]   & {SW{c_tok[i]}});
    end
  end

  assign any_match = |c_match;
  assign any_fit   = |c_fit;
  assign last_k    = (CW'(k) + CW'(1)) >= count;
  assign old_len   = oe - SW'(os);
  assign resp_go   = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // request sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    k_next         = k;
    rz_next        = rz;
    os_next        = os;
    oe_next        = oe;
    ridx_next      = ridx;
    res_ok_next    = res_ok;
    res_off_next   = res_off;
    res_moved_next = res_moved;
    res_copy_next  = res_copy;
    ctl            = '0;
    c_idx          = '0;
    c_new_start    = '0;
    c_new_end      = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISP;
        end
      end

      S_DISP: begin
        res_ok_next    = 1'b0;
        res_off_next   = '0;
        res_moved_next = 1'b0;
        res_copy_next  = '0;
        rz_next        = 1'b0;
        k_next         = '0;
        unique case (op)
          ffsa_pkg::OP_ALLOC: begin
            state_next = S_ACHK;
          end
          ffsa_pkg::OP_FREE: begin
            if (hb && count != '0) begin
              ctl.scan_start = 1'b1;
              state_next     = S_FIND;
            end else begin
              state_next = S_RESP;
            end
          end
          ffsa_pkg::OP_RESIZE: begin
            if (req_size != '0 && !hb) begin
              state_next = S_ACHK;
            end else if (hb && count != '0) begin
              ctl.scan_start = 1'b1;
              state_next     = S_FIND;
            end else begin
              state_next = S_RESP;
            end
          end
          ffsa_pkg::OP_CLEAR: begin
            count_next = '0;
            state_next = S_RESP;
          end
          default: state_next = S_RESP;
        endcase
      end

      // walk the table for the segment that starts at the given offset
      S_FIND: begin
        if (any_match) begin
          ctl.rem    = 1'b1;
          c_idx      = k;
          count_next = count - CW'(1);
          if (op == ffsa_pkg::OP_FREE || req_size == '0) begin
            state_next = S_RESP;
          end else begin
            os_next    = sel_start;
            oe_next    = sel_end;
            ridx_next  = k;
            rz_next    = 1'b1;
            state_next = S_ACHK;
          end
        end else if (last_k) begin
          state_next = S_RESP;
        end else begin
          k_next = k + IW'(1);
        end
      end

      // pool checks and the gap before the first segment
      S_ACHK: begin
        k_next = '0;
        if (pool_u == '0 || req_size > pool_u ||
            (req_size != '0 && count >= FULL)) begin
          state_next = S_RESP;
          if (rz) begin
            ctl.ins     = 1'b1;
            c_idx       = ridx;
            c_new_start = os;
            c_new_end   = oe;
            count_next  = count + CW'(1);
          end
        end else if (req_size == '0) begin
          res_ok_next = 1'b1;
          state_next  = S_RESP;
        end else if (count == '0 || SW'(c_start[0]) >= req_size) begin
          ctl.ins        = 1'b1;
          c_idx          = '0;
          c_new_start    = '0;
          c_new_end      = req_size;
          count_next     = count + CW'(1);
          res_ok_next    = 1'b1;
          res_off_next   = '0;
          res_moved_next = rz && (os != '0);
          res_copy_next  = (rz && os != '0) ?
                           ((req_size < old_len) ? req_size : old_len) : '0;
          state_next     = S_RESP;
        end else begin
          ctl.scan_start = 1'b1;
          state_next     = S_ASCAN;
        end
      end

      // walk the gaps after each segment
      S_ASCAN: begin
        if (any_fit) begin
          ctl.ins        = 1'b1;
          c_idx          = k + IW'(1);
          c_new_start    = OB'(sel_end);
          c_new_end      = sel_end + req_size;
          count_next     = count + CW'(1);
          res_ok_next    = 1'b1;
          res_off_next   = OB'(sel_end);
          res_moved_next = rz && (OB'(sel_end) != os);
          res_copy_next  = (rz && OB'(sel_end) != os) ?
                           ((req_size < old_len) ? req_size : old_len) : '0;
          state_next     = S_RESP;
        end else if (last_k) begin
          state_next = S_RESP;
          if (rz) begin
            ctl.ins     = 1'b1;
            c_idx       = ridx;
            c_new_start = os;
            c_new_end   = oe;
            count_next  = count + CW'(1);
          end
        end else begin
          k_next = k + IW'(1);
        end
      end

      S_RESP: begin
        if (resp_go) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    k         <= k_next;
    rz        <= rz_next;
    os        <= os_next;
    oe        <= oe_next;
    ridx      <= ridx_next;
    res_ok    <= res_ok_next;
    res_off   <= res_off_next;
    res_moved <= res_moved_next;
    res_copy  <= res_copy_next;
    if (state == S_IDLE && in_valid) begin
      op       <= operation;
      hb       <= has_block;
      off      <= block_offset;
      req_size <= size;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && resp_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && resp_go) begin
      has_result    <= res_ok;
      result_offset <= res_ok ? res_off : '0;
      moved         <= res_ok && res_moved;
      copy_length   <= res_ok ? res_copy : '0;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("segment count above table depth");

  a_token_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(c_tok))
    else $error("more than one scan token in the cell row");

  a_null_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_result) |-> (result_offset == '0 && !moved && copy_length == '0))
    else $error("null result carries nonzero fields");

  a_busy_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND || state == S_ASCAN) |-> (c_tok != '0))
    else $error("table walk without a scan token");

endmodule

`default_nettype wire

/* rtl/ffsa_cell.sv */
// ----------------------------------------------------------------------------
// ffsa_cell: one entry of the segment table
// Holds one segment, shifts with its neighbors on insert and remove, and
// evaluates the match and gap tests while it holds the scan token.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_cell #(
  parameter int POS         = 0,
  parameter int OFFSET_BITS = ffsa_pkg::DEF_OFFSET_BITS,
  parameter int MAXS        = ffsa_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ffsa_pkg::ffsa_ctl_t         ctl,
  input  wire logic [$clog2(MAXS)-1:0]     idx,
  input  wire logic [OFFSET_BITS-1:0]      new_start,
  input  wire logic [OFFSET_BITS:0]        new_end,
  input  wire logic [OFFSET_BITS-1:0]      left_start,
  input  wire logic [OFFSET_BITS:0]        left_end,
  input  wire logic [OFFSET_BITS-1:0]      right_start,
  input  wire logic [OFFSET_BITS:0]        right_end,
  input  wire logic [OFFSET_BITS-1:0]      next_start,
  input  wire logic                        tok_prev,
  input  wire logic [$clog2(MAXS+1)-1:0]   count,
  input  wire logic [OFFSET_BITS:0]        pool,
  input  wire logic [OFFSET_BITS:0]        size,
  input  wire logic [OFFSET_BITS-1:0]      off,
  output logic [OFFSET_BITS-1:0]           seg_start,
  output logic [OFFSET_BITS:0]             seg_end,
  output logic                             tok,
  output logic                             match,
  output logic                             fit
);

  localparam int IW = $clog2(MAXS);
  localparam int CW = $clog2(MAXS+1);
  localparam int SW = OFFSET_BITS + 1;
  localparam logic [IW-1:0] ID       = IW'(POS);
  localparam logic [CW-1:0] NEXT_POS = CW'(POS + 1);
  localparam logic          IS_FIRST = (POS == 0);

  logic [SW-1:0] lim;
  logic          has_next;

  // segment storage, shifting with the neighbors
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (ID > idx) begin
        seg_start <= left_start;
        seg_end   <= left_end;
      end else if (ID == idx) begin
        seg_start <= new_start;
        seg_end   <= new_end;
      end
    end else if (ctl.rem && ID >= idx) begin
      seg_start <= right_start;
      seg_end   <= right_end;
    end
  end

  // scan token moves one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctl.scan_start) begin
      tok <= IS_FIRST;
    end else begin
      tok <= tok_prev;
    end
  end

  // gap after this segment ends at the next start or at the pool end
  assign has_next = NEXT_POS < count;
  assign lim      = has_next ? {1'b0, next_start} : pool;

  assign match = tok && (seg_start == off);
  assign fit   = tok && (lim >= seg_end) && ((lim - seg_end) >= size);

endmodule

`default_nettype wire
